>>> rtl/dfs_pkg.sv
package dfs_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] REG_BREAK = 2'd0;
  localparam logic [1:0] REG_MAB   = 2'd1;
  localparam logic [1:0] REG_BIT   = 2'd2;

  // reset values of the registers
  localparam logic [15:0] BREAK_RST = 16'd92;
  localparam logic [15:0] MAB_RST   = 16'd12;
  localparam logic [9:0]  BIT_RST   = 10'd4;

  // segment steps of the back end sequencer
  localparam logic [3:0] STEP_BREAK = 4'd0;
  localparam logic [3:0] STEP_MAB   = 4'd1;
  localparam logic [3:0] STEP_START = 4'd2;
  localparam logic [3:0] STEP_DATA0 = 4'd3;
  localparam logic [3:0] STEP_STOP  = 4'd11;

  // null start code sent after the mark-after-break
  localparam logic [7:0] START_CODE = 8'h00;

  // classified command between front end and back end
  typedef struct packed {
    logic       is_frame;
    logic [7:0] data_byte;
  } cmd_t;

  // live configuration, zero lengths already raised to one
  typedef struct packed {
    logic [15:0] break_len;
    logic [15:0] mab_len;
    logic [9:0]  bit_len;
  } cfg_t;

  // one line segment
  typedef struct packed {
    logic        level;
    logic [15:0] samples;
    logic        last;
  } seg_t;

endpackage

>>> rtl/dmx512_frame_serializer.sv
// channel  | direction | handshake              | payload
// in_      | slave     | in_tvalid / in_tready   | tuser: func, tdata: slot_byte
// out_     | master    | out_tvalid / out_tready | tdata: line_level, segment_samples;
//          |           |                         | tlast: last_segment
// cfg_     | slave     | cfg_valid / cfg_ready   | cfg_index, cfg_data (always ready)
//
// the back end emits one segment per cycle unless the output stalls. a slot
// is start, data and stop segments; a frame start puts break and mark-after-break
// first; front end and queue accept input meanwhile, so items stream with no gaps.
// reset is synchronous and active low; registers return to 92 / 12 / 4.
// a stalled output holds its segment; the queue absorbs input while it stalls.
module dmx512_frame_serializer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] slot_byte
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] line_level, [16:1] segment_samples, rest zero
  output logic        out_tlast,  // last_segment
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dfs_pkg::*;

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  push_valid;
  logic  push_ready;
  cmd_t  push_cmd;
  logic  pop_valid;
  logic  pop_ready;
  cmd_t  pop_cmd;
  seg_t  seg;

  // configuration registers, a zero length is kept as one
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BREAK: cfg_nxt.break_len = (cfg_data == '0) ? 16'd1 : cfg_data;
        REG_MAB:   cfg_nxt.mab_len   = (cfg_data == '0) ? 16'd1 : cfg_data;
        REG_BIT:   cfg_nxt.bit_len   = (cfg_data[9:0] == '0) ? 10'd1 : cfg_data[9:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.break_len <= BREAK_RST;
      cfg_r.mab_len   <= MAB_RST;
      cfg_r.bit_len   <= BIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: accept and classify
  dfs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .func       (in_tuser),
    .slot_byte  (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // command queue
  dfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back end: segment sequencer
  dfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_seg   (seg)
  );

  assign out_tdata = {7'd0, seg.samples, seg.level};
  assign out_tlast = seg.last;

endmodule

>>> rtl/dfs_front.sv
module dfs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          func,
  input  logic [7:0]    slot_byte,
  output logic          push_valid,
  input  logic          push_ready,
  output dfs_pkg::cmd_t push_cmd
);
  import dfs_pkg::*;

  logic valid_r;
  logic valid_nxt;
  cmd_t cmd_r;
  cmd_t cmd_nxt;

  // input stage takes a new transaction when empty or when its entry moves on
  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_cmd   = cmd_r;

  // classify: frame start carries the null start code as its character
  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (in_valid && in_ready) begin
      valid_nxt          = 1'b1;
      cmd_nxt.is_frame   = !func;
      cmd_nxt.data_byte  = func ? slot_byte : START_CODE;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

>>> rtl/dfs_queue.sv
module dfs_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  dfs_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output dfs_pkg::cmd_t pop_cmd
);
  import dfs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/dfs_back.sv
module dfs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  dfs_pkg::cfg_t cfg,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  dfs_pkg::cmd_t pop_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output dfs_pkg::seg_t out_seg
);
  import dfs_pkg::*;

  logic       active_r;
  logic       active_nxt;
  cmd_t       cmd_r;
  cmd_t       cmd_nxt;
  logic [3:0] step_r;
  logic [3:0] step_nxt;
  logic       oval_r;
  logic       oval_nxt;
  seg_t       oseg_r;
  seg_t       oseg_nxt;
  seg_t       seg_cur;
  logic       load;
  logic [2:0] bit_idx;
  logic [10:0] stop_len;

  assign out_valid = oval_r;
  assign out_seg   = oseg_r;

  // output register frees when empty or when its transaction completes
  assign load      = active_r && (!oval_r || out_ready);
  assign pop_ready = !active_r || (load && seg_cur.last);

  assign bit_idx  = 3'(step_r - STEP_DATA0);
  assign stop_len = {cfg.bit_len, 1'b0};

  // segment of the current step
  always_comb begin
    seg_cur.last = (step_r == STEP_STOP);
    unique case (step_r)
      STEP_BREAK: begin
        seg_cur.level   = 1'b0;
        seg_cur.samples = cfg.break_len;
      end
      STEP_MAB: begin
        seg_cur.level   = 1'b1;
        seg_cur.samples = cfg.mab_len;
      end
      STEP_START: begin
        seg_cur.level   = 1'b0;
        seg_cur.samples = 16'(cfg.bit_len);
      end
      STEP_STOP: begin
        seg_cur.level   = 1'b1;
        seg_cur.samples = 16'(stop_len);
      end
      default: begin
        seg_cur.level   = cmd_r.data_byte[bit_idx];
        seg_cur.samples = 16'(cfg.bit_len);
      end
    endcase
  end

  // step sequencer, picks the next command straight after a stop segment
  always_comb begin
    active_nxt = active_r;
    cmd_nxt    = cmd_r;
    step_nxt   = step_r;
    if (load) begin
      step_nxt = step_r + 1'b1;
    end
    if (pop_ready) begin
      active_nxt = pop_valid;
      cmd_nxt    = pop_cmd;
      step_nxt   = pop_cmd.is_frame ? STEP_BREAK : STEP_START;
    end
  end

  // output register
  always_comb begin
    oval_nxt = oval_r;
    oseg_nxt = oseg_r;
    if (load) begin
      oval_nxt = 1'b1;
      oseg_nxt = seg_cur;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= STEP_BREAK;
      oval_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      step_r   <= step_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    oseg_r <= oseg_nxt;
  end

endmodule

>>> rtl/dfs_checker.sv
module dfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_ready
);

  // a stalled segment holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output segment changed while stalled");

  // no segment has zero duration
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:1] != 16'd0)
    else $error("zero length segment");

  // every item ends on the high stop segment
  a_last_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[0] && out_tdata[16:1] != 16'd1)
    else $error("last segment is not a stop segment");

  // nothing comes out in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("output valid straight after reset");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind dmx512_frame_serializer dfs_checker u_dfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_ready  (cfg_ready)
);
